@@ rtl/core/gdsc_pkg.sv @@
// Shared types, constants and calendar functions of the Gregorian date step calculator.
package gdsc_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [MonthW-1:0] MonthsPerYear = 4'd12;

  localparam logic [DayW-1:0] DaysFebCommon = 5'd28;
  localparam logic [DayW-1:0] DaysFebLeap   = 5'd29;
  localparam logic [DayW-1:0] DaysShort     = 5'd30;
  localparam logic [DayW-1:0] DaysLong      = 5'd31;
  localparam logic [DayW-1:0] DaysPerWeek   = 5'd7;

  // Exact divisibility by 25: y * inv(25) mod 2^14 stays at or below floor((2^14-1)/25).
  localparam logic [YearW-1:0] Inv25    = 14'd7209;
  localparam logic [YearW-1:0] Div25Max = 14'd655;

  typedef enum logic [1:0] {
    ModeAddMonths = 2'd0,
    ModeAddWeek   = 2'd1,
    ModeDiff      = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YearW-1:0]  other_year;
    logic [MonthW-1:0] other_month;
    logic [DayW-1:0]   other_day;
  } date_item_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              order_error;
  } result_t;

  // Leap when divisible by 4, except centuries not divisible by 400.
  function automatic logic leap_year(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = YearW'(y * Inv25);
    div25 = (prod <= Div25Max);
    if (y[1:0] != 2'b00) begin
      return 1'b0;
    end else if (!div25) begin
      return 1'b1;
    end else begin
      return (y[3:0] == 4'b0000);
    end
  endfunction

  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                   input logic leap);
    logic [DayW-1:0] len;
    case (m) inside
      MonthFeb:                             len = leap ? DaysFebLeap : DaysFebCommon;
      MonthApr, MonthJun, MonthSep, MonthNov: len = DaysShort;
      default:                              len = DaysLong;
    endcase
    return len;
  endfunction

  function automatic logic [MonthW-1:0] fix_month(input logic [MonthW-1:0] m);
    logic [MonthW-1:0] r;
    r = m;
    if (m == '0) begin
      r = MonthJan;
    end else if (m > MonthDec) begin
      r = MonthDec;
    end
    return r;
  endfunction

  function automatic logic [MonthW-1:0] prev_month(input logic [MonthW-1:0] m);
    return (m == MonthJan) ? MonthDec : m - 4'd1;
  endfunction

endpackage

@@ rtl/core/gdsc_calc.sv @@
// Date arithmetic for one item: add two months, add one week, or date difference.
module gdsc_calc (
  input  gdsc_pkg::date_item_t item_i,
  output gdsc_pkg::result_t    result_o
);

  logic [gdsc_pkg::YearW-1:0]  y, oy, y_next;
  logic [gdsc_pkg::MonthW-1:0] m, om;
  logic [gdsc_pkg::DayW-1:0]   d, od;
  logic                        leap_y, leap_yn;

  // add two months
  logic [gdsc_pkg::YearW-1:0]  ry0;
  logic [gdsc_pkg::MonthW-1:0] rm0;
  logic [gdsc_pkg::DayW-1:0]   rd0, len0;

  // add one week
  logic [gdsc_pkg::YearW-1:0]  ry1;
  logic [gdsc_pkg::MonthW-1:0] rm1;
  logic [gdsc_pkg::DayW-1:0]   rd1, len1;
  logic [gdsc_pkg::DayW:0]     sum1;

  // difference
  logic                        later;
  logic [gdsc_pkg::MonthW-1:0] p1, p2;
  logic signed [6:0]           sd0, sd1, sd2, sd;
  logic [1:0]                  borrows;
  logic signed [5:0]           sm;
  logic signed [gdsc_pkg::YearW+1:0] sy;
  logic                        err2;

  always_comb begin
    y  = item_i.year;
    oy = item_i.other_year;
    m  = gdsc_pkg::fix_month(item_i.month);
    om = gdsc_pkg::fix_month(item_i.other_month);
    d  = item_i.day;
    od = item_i.other_day;
    y_next  = y + 14'd1;
    leap_y  = gdsc_pkg::leap_year(y);
    leap_yn = gdsc_pkg::leap_year(y_next);

    // Target month two ahead; clamp the day into it.
    rm0 = m + 4'd2;
    ry0 = y;
    if (rm0 > gdsc_pkg::MonthsPerYear) begin
      rm0  = rm0 - gdsc_pkg::MonthsPerYear;
      ry0  = y_next;
      len0 = gdsc_pkg::month_length(rm0, leap_yn);
    end else begin
      len0 = gdsc_pkg::month_length(rm0, leap_y);
    end
    rd0 = (d > len0) ? len0 : d;
    if (rd0 == '0) begin
      rd0 = 5'd1;
    end

    // Week step; roll excess days into the next month.
    len1 = gdsc_pkg::month_length(m, leap_y);
    sum1 = {1'b0, d} + {1'b0, gdsc_pkg::DaysPerWeek};
    ry1  = y;
    rm1  = m;
    rd1  = sum1[gdsc_pkg::DayW-1:0];
    if (sum1 > {1'b0, len1}) begin
      rd1 = gdsc_pkg::DayW'(sum1 - {1'b0, len1});
      if (m == gdsc_pkg::MonthDec) begin
        rm1 = gdsc_pkg::MonthJan;
        ry1 = y_next;
      end else begin
        rm1 = m + 4'd1;
      end
    end

    // Difference. A borrowed February always lies in the base year.
    later = (y < oy) || (y == oy && m < om) || (y == oy && m == om && d < od);
    p1  = gdsc_pkg::prev_month(m);
    p2  = gdsc_pkg::prev_month(p1);
    sd0 = $signed({2'b00, d}) - $signed({2'b00, od});
    sd1 = sd0 + $signed({2'b00, gdsc_pkg::month_length(p1, leap_y)});
    sd2 = sd1 + $signed({2'b00, gdsc_pkg::month_length(p2, leap_y)});
    if (sd0 >= 0) begin
      sd      = sd0;
      borrows = 2'd0;
    end else if (sd1 >= 0) begin
      sd      = sd1;
      borrows = 2'd1;
    end else begin
      sd      = sd2;
      borrows = 2'd2;
    end
    if (sd < 0) begin
      sd = '0;
    end
    sm = $signed({2'b00, m}) - $signed({2'b00, om}) - $signed({4'b0000, borrows});
    sy = $signed({2'b00, y}) - $signed({2'b00, oy});
    // At most two month wraps: the month span is never below -13.
    if (sm < 0) begin
      sm = sm + 6'sd12;
      sy = sy - 16'sd1;
      if (sm < 0) begin
        sm = sm + 6'sd12;
        sy = sy - 16'sd1;
      end
    end
    err2 = later || (sy < 0);

    result_o = '0;
    unique case (gdsc_pkg::mode_e'(item_i.mode))
      gdsc_pkg::ModeAddMonths: begin
        result_o.year  = ry0;
        result_o.month = rm0;
        result_o.day   = rd0;
      end
      gdsc_pkg::ModeAddWeek: begin
        result_o.year  = ry1;
        result_o.month = rm1;
        result_o.day   = rd1;
      end
      gdsc_pkg::ModeDiff: begin
        if (err2) begin
          result_o.order_error = 1'b1;
        end else begin
          result_o.year  = sy[gdsc_pkg::YearW-1:0];
          result_o.month = sm[gdsc_pkg::MonthW-1:0];
          result_o.day   = sd[gdsc_pkg::DayW-1:0];
        end
      end
      default: result_o = '0;
    endcase
  end

endmodule

@@ rtl/core/gregorian_date_step_calculator.sv @@
// Top level: input register, date arithmetic, result register.
//
// Usage: present an item (mode, base date, other date) with in_valid_i; it is
// taken at a rising edge where in_valid_i and in_ready_o are both high. Each
// item yields exactly one result on out_year_o, out_month_o, out_day_o and
// order_error_o, handed over when out_valid_o and out_ready_i are both high.
// Results leave in the order the items came in.
//
// Flow: the accepting edge loads the input register, and the result register
// loads from it once the result stage is free and raises out_valid_o, so a
// result leaves after both registers. Throughput: one item per cycle while
// out_ready_i stays high; the whole calculation fits between the two registers,
// the leap test costing one 14-bit constant multiply.
//
// Reset clears both valid flags; in_ready_o stays low while rst_ni is low and
// rises with it. When the receiver stalls, the result register holds, the
// input register still takes one more item, and in_ready_o then drops until
// the result is taken. Nothing is dropped or repeated.
module gregorian_date_step_calculator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [13:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [13:0] other_year_i,
  input  logic [3:0]  other_month_i,
  input  logic [4:0]  other_day_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [13:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic        order_error_o
);

  gdsc_pkg::date_item_t item_d, item_q;
  gdsc_pkg::result_t    res_d, res_q;
  logic                 in_vld_q, out_vld_q;
  logic                 res_ready;

  assign res_ready  = !out_vld_q || out_ready_i;
  assign in_ready_o = rst_ni && (!in_vld_q || res_ready);

  always_comb begin
    item_d.mode        = mode_i;
    item_d.year        = year_i;
    item_d.month       = month_i;
    item_d.day         = day_i;
    item_d.other_year  = other_year_i;
    item_d.other_month = other_month_i;
    item_d.other_day   = other_day_i;
  end

  gdsc_calc u_calc (
    .item_i  (item_q),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (res_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Payload registers: load only on advance, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
    if (res_ready && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_year_o    = res_q.year;
  assign out_month_o   = res_q.month;
  assign out_day_o     = res_q.day;
  assign order_error_o = res_q.order_error;

  // An error result carries an all-zero span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.order_error |->
      res_q.year == '0 && res_q.month == '0 && res_q.day == '0)
    else $error("order error with nonzero span");

  // Result month never exceeds twelve.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> res_q.month <= gdsc_pkg::MonthDec)
    else $error("result month out of range");

  // A held item stays held while the result stage is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !res_ready |=> in_vld_q && $stable(item_q))
    else $error("input stage lost a blocked item");

  // Back pressure reaches the input only when both stages are full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q && !out_ready_i)
    else $error("input ready dropped without a full stall");

  // A result taken with an item waiting is replaced in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_ready_i && in_vld_q |=> out_vld_q)
    else $error("result stage emptied with an item pending");

endmodule

@@ tb/sv/tb_gregorian_date_step_calculator.sv @@
// Self-checking testbench for the Gregorian date step calculator with random flow control.
module tb_gregorian_date_step_calculator;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int YearSpan = 1 << gdsc_pkg::YearW;
  localparam int RandomDates = 1600;
  localparam int StallLen = 80;
  localparam int DrainCycles = 8;
  localparam int CycleLimit = 200000;
  localparam int MaxPrinted = 40;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [1:0]                  mode_i = '0;
  logic [gdsc_pkg::YearW-1:0]  year_i = '0;
  logic [gdsc_pkg::MonthW-1:0] month_i = '0;
  logic [gdsc_pkg::DayW-1:0]   day_i = '0;
  logic [gdsc_pkg::YearW-1:0]  other_year_i = '0;
  logic [gdsc_pkg::MonthW-1:0] other_month_i = '0;
  logic [gdsc_pkg::DayW-1:0]   other_day_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [gdsc_pkg::YearW-1:0]  out_year_o;
  logic [gdsc_pkg::MonthW-1:0] out_month_o;
  logic [gdsc_pkg::DayW-1:0]   out_day_o;
  logic                        order_error_o;

  gdsc_pkg::date_item_t pending_dates[$];
  gdsc_pkg::result_t    predicted_dates[$];
  int         dates_total = 0;
  int         dates_accepted = 0;
  int         dates_checked = 0;
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  logic       in_taken = 1'b0;
  logic       out_taken = 1'b0;
  logic       rx_hold = 1'b0;
  logic       tx_calm = 1'b0;
  logic       rx_calm = 1'b0;
  int         tx_wait = 0;
  int         rx_wait = 0;

  gregorian_date_step_calculator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .year_i        (year_i),
    .month_i       (month_i),
    .day_i         (day_i),
    .other_year_i  (other_year_i),
    .other_month_i (other_month_i),
    .other_day_i   (other_day_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_year_o    (out_year_o),
    .out_month_o   (out_month_o),
    .out_day_o     (out_day_o),
    .order_error_o (order_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int clamp_month(input int m);
    if (m == 0) begin
      return 1;
    end else if (m > 12) begin
      return 12;
    end
    return m;
  endfunction

  function automatic int days_in(input int m, input int y);
    logic leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      2: return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic gdsc_pkg::result_t step_date(input gdsc_pkg::date_item_t it);
    gdsc_pkg::result_t r;
    int y, m, d, oy, om, od;
    int ry, rm, rd, len, sd, sm, sy, cm, cy, borrows;
    y  = it.year;
    m  = clamp_month(it.month);
    d  = it.day;
    oy = it.other_year;
    om = clamp_month(it.other_month);
    od = it.other_day;
    ry = 0;
    rm = 0;
    rd = 0;
    r  = '0;
    case (it.mode)
      gdsc_pkg::ModeAddMonths: begin
        ry = y;
        rm = m + 2;
        if (rm > 12) begin
          rm = rm - 12;
          ry = (y + 1) % YearSpan;
        end
        len = days_in(rm, ry);
        rd  = (d > len) ? len : d;
        if (rd == 0) rd = 1;
      end
      gdsc_pkg::ModeAddWeek: begin
        len = days_in(m, y);
        ry  = y;
        rm  = m;
        rd  = d + 7;
        if (rd > len) begin
          rd = rd - len;
          if (m == 12) begin
            rm = 1;
            ry = (y + 1) % YearSpan;
          end else begin
            rm = m + 1;
          end
        end
      end
      gdsc_pkg::ModeDiff: begin
        if ((y < oy) || (y == oy && m < om) || (y == oy && m == om && d < od)) begin
          r.order_error = 1'b1;
        end else begin
          // borrow whole months, walking back from the base month
          sd = d - od;
          cm = m;
          cy = y;
          borrows = 0;
          while (sd < 0 && borrows < 2) begin
            if (cm == 1) begin
              cm = 12;
              cy = (cy + YearSpan - 1) % YearSpan;
            end else begin
              cm = cm - 1;
            end
            sd = sd + days_in(cm, cy);
            borrows++;
          end
          if (sd < 0) sd = 0;
          sm = m - om - borrows;
          sy = y - oy;
          while (sm < 0) begin
            sm = sm + 12;
            sy = sy - 1;
          end
          if (sy < 0) begin
            r.order_error = 1'b1;
          end else begin
            ry = sy;
            rm = sm;
            rd = sd;
          end
        end
      end
      default: ;
    endcase
    r.year  = gdsc_pkg::YearW'(ry);
    r.month = gdsc_pkg::MonthW'(rm);
    r.day   = gdsc_pkg::DayW'(rd);
    return r;
  endfunction

  function automatic int pick_year();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, YearSpan - 1);
      1: return $urandom_range(0, 99) * 100;
      2: begin
        case ($urandom_range(0, 3))
          0: return 0;
          1: return 1;
          2: return 9999;
          default: return YearSpan - 1;
        endcase
      end
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  function automatic int pick_month();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 15);
    end
    return $urandom_range(1, 12);
  endfunction

  function automatic int pick_day(input int m, input int y);
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 31);
    end
    return $urandom_range(1, days_in(clamp_month(m), y));
  endfunction

  task automatic queue_date(input logic [1:0] mode, input int y, input int m, input int d,
                            input int oy, input int om, input int od);
    gdsc_pkg::date_item_t it;
    it.mode        = mode;
    it.year        = gdsc_pkg::YearW'(y);
    it.month       = gdsc_pkg::MonthW'(m);
    it.day         = gdsc_pkg::DayW'(d);
    it.other_year  = gdsc_pkg::YearW'(oy);
    it.other_month = gdsc_pkg::MonthW'(om);
    it.other_day   = gdsc_pkg::DayW'(od);
    pending_dates.push_back(it);
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatch_cnt < MaxPrinted) begin
      $display("[%0d] date check failed: %s", cycle_cnt, what);
    end
    mismatch_cnt++;
  endtask

  // sender: offer pending items with a random gap after each one
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // hold the offered item until it is taken
    end else if (tx_wait > 0) begin
      in_valid_i <= 1'b0;
      tx_wait = tx_wait - 1;
    end else if (pending_dates.size() > 0) begin
      in_valid_i    <= 1'b1;
      mode_i        <= pending_dates[0].mode;
      year_i        <= pending_dates[0].year;
      month_i       <= pending_dates[0].month;
      day_i         <= pending_dates[0].day;
      other_year_i  <= pending_dates[0].other_year;
      other_month_i <= pending_dates[0].other_month;
      other_day_i   <= pending_dates[0].other_day;
      void'(pending_dates.pop_front());
      if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
      tx_wait = tx_calm ? 0 : $urandom_range(0, 4);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver: stall a random number of cycles after each result
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 4);
      end
      if (rx_hold || rx_wait > 0) begin
        out_ready_i <= 1'b0;
        if (rx_wait > 0) rx_wait = rx_wait - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    gdsc_pkg::result_t want;
    cycle_cnt <= cycle_cnt + 1;
    in_taken  <= rst_ni && in_valid_i && in_ready_o;
    out_taken <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_dates.size() == 0) begin
        flag_mismatch($sformatf("result %0d/%0d/%0d err %0b with nothing pending",
                                out_year_o, out_month_o, out_day_o, order_error_o));
      end else begin
        want = predicted_dates.pop_front();
        if (out_year_o !== want.year)
          flag_mismatch($sformatf("result %0d: year %0d, predicted %0d",
                                  dates_checked, out_year_o, want.year));
        if (out_month_o !== want.month)
          flag_mismatch($sformatf("result %0d: month %0d, predicted %0d",
                                  dates_checked, out_month_o, want.month));
        if (out_day_o !== want.day)
          flag_mismatch($sformatf("result %0d: day %0d, predicted %0d",
                                  dates_checked, out_day_o, want.day));
        if (order_error_o !== want.order_error)
          flag_mismatch($sformatf("result %0d: order_error %0b, predicted %0b",
                                  dates_checked, order_error_o, want.order_error));
      end
      dates_checked <= dates_checked + 1;
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      predicted_dates.push_back(step_date({mode_i, year_i, month_i, day_i,
                                           other_year_i, other_month_i, other_day_i}));
      dates_accepted <= dates_accepted + 1;
    end
  end

  // hold the receiver off twice so the pipeline fills and backs up
  initial begin
    for (int k = 0; k < 2; k++) begin
      while (dates_accepted < (k + 1) * 500) @(posedge clk_i);
      rx_hold <= 1'b1;
      repeat (StallLen) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("gregorian_date_step_calculator: mismatch");
    $finish;
  end

  initial begin
    int y, m, d, oy, om, od;
    logic [1:0] mode;

    // add two months: leap and century Februaries, clamping, odd months, year wrap
    queue_date(gdsc_pkg::ModeAddMonths, 2023, 12, 31, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddMonths, 2022, 12, 31, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddMonths, 1899, 12, 31, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddMonths, 1999, 12, 30, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddMonths, 2024, 2, 31, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddMonths, 9999, 1, 0, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddMonths, 1, 0, 31, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddMonths, 500, 15, 31, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddMonths, YearSpan - 1, 11, 31, YearSpan - 1, 15, 31);
    // add a week: year and month rollover, day zero, leap February
    queue_date(gdsc_pkg::ModeAddWeek, 9999, 12, 28, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddWeek, 2024, 2, 22, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddWeek, 2023, 2, 22, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddWeek, 1900, 2, 31, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddWeek, 1, 6, 0, 0, 0, 0);
    queue_date(gdsc_pkg::ModeAddWeek, YearSpan - 1, 12, 31, 0, 0, 0);
    // difference: equal dates, later by day, month and year, borrows, negative span
    queue_date(gdsc_pkg::ModeDiff, 2024, 5, 17, 2024, 5, 17);
    queue_date(gdsc_pkg::ModeDiff, 2024, 5, 17, 2024, 5, 18);
    queue_date(gdsc_pkg::ModeDiff, 2024, 5, 17, 2024, 6, 1);
    queue_date(gdsc_pkg::ModeDiff, 2024, 5, 17, 2025, 1, 1);
    queue_date(gdsc_pkg::ModeDiff, 2024, 1, 5, 2023, 12, 20);
    queue_date(gdsc_pkg::ModeDiff, 2024, 3, 1, 2024, 1, 31);
    queue_date(gdsc_pkg::ModeDiff, 2023, 3, 1, 2023, 2, 31);
    queue_date(gdsc_pkg::ModeDiff, 0, 1, 0, 0, 0, 31);
    queue_date(gdsc_pkg::ModeDiff, YearSpan - 1, 15, 31, 1, 0, 0);
    queue_date(ModeUnused, 2024, 6, 15, 2000, 1, 1);

    repeat (RandomDates) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: mode = gdsc_pkg::ModeAddMonths;
        5, 6, 7, 8, 9: mode = gdsc_pkg::ModeAddWeek;
        15: mode = ModeUnused;
        default: mode = gdsc_pkg::ModeDiff;
      endcase
      y = pick_year();
      m = pick_month();
      d = pick_day(m, y);
      if (mode == gdsc_pkg::ModeDiff) begin
        case ($urandom_range(0, 3))
          0: begin
            oy = pick_year();
            om = pick_month();
          end
          1: begin
            oy = y;
            om = m;
          end
          default: begin
            oy = y - $urandom_range(0, 2);
            if (oy < 0) oy = y;
            om = pick_month();
          end
        endcase
        od = pick_day(om, oy);
      end else begin
        // other date is ignored here; keep it noisy
        oy = $urandom_range(0, YearSpan - 1);
        om = $urandom_range(0, 15);
        od = $urandom_range(0, 31);
      end
      queue_date(mode, y, m, d, oy, om, od);
    end
    dates_total = pending_dates.size();

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (dates_accepted < dates_total || predicted_dates.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("gregorian_date_step_calculator: match");
    end else begin
      $display("gregorian_date_step_calculator: mismatch");
    end
    $finish;
  end

endmodule
